@@ rtl/parameterized_substring_match_count_unit_macros.svh @@
// Assertion macros shared by the substring match counter.
`ifndef PARAMETERIZED_SUBSTRING_MATCH_COUNT_UNIT_MACROS_SVH
`define PARAMETERIZED_SUBSTRING_MATCH_COUNT_UNIT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PSMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PSMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/psmc_pkg.sv @@
package psmc_pkg;

  // Command codes carried with each input item.
  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  localparam int NUM_LETTERS = 26;
  localparam int LETTER_BITS = 5;
  localparam logic [LETTER_BITS-1:0] LETTER_MAX = 5'd25;
  localparam int OUT_COUNT_BITS = 24;
  localparam int POS_BITS = 24;

  // Control that travels along the cell row with a text letter.
  typedef struct packed {
    logic text_en;
    logic clear;
  } cell_ctl_t;

endpackage

@@ rtl/psmc_cell.sv @@
// One window cell: holds the text distance of one window slot and the
// pattern distance of the same slot, and shifts both to its neighbor.
module psmc_cell #(
  parameter int DIST_BITS = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psmc_pkg::cell_ctl_t   ctl,
  input  logic [DIST_BITS-1:0]  dist_in,
  output logic [DIST_BITS-1:0]  dist_out,
  input  logic                  pat_we,
  input  logic [DIST_BITS-1:0]  pat_in,
  output logic [DIST_BITS-1:0]  pat_out,
  input  logic [DIST_BITS-1:0]  off_k,
  input  logic                  active,
  output logic                  ok
);

  logic [DIST_BITS-1:0] win_r;
  logic [DIST_BITS-1:0] pat_r;
  logic [DIST_BITS-1:0] win_clip;

  // Text distance shift register slot.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      win_r <= '0;
    end else if (ctl.text_en) begin
      win_r <= dist_in;
    end
  end

  // Pattern distance shift register slot; a new pattern letter enters at the
  // top, so pattern offsets line up with the window slots of the same cells.
  always_ff @(posedge clk) begin
    if (pat_we) begin
      pat_r <= pat_in;
    end
  end

  assign dist_out = win_r;
  assign pat_out = pat_r;
  assign win_clip = (win_r > off_k) ? '0 : win_r;
  assign ok = !active || (win_clip == pat_r);

endmodule

@@ rtl/parameterized_substring_match_count_unit.sv @@
// A text item is shifted into the cell row when it is accepted; then, in
// the EVAL state, it is compared across all cells and the result is put in
// the output register. No new item is taken in EVAL or while out is stalled.
// Pattern, restart and unused items give no result.
// Reset (rst_n low, synchronous) clears the pattern, window, counts and
// the output valid flag; there is no clearing pass.
module parameterized_substring_match_count_unit #(
  parameter int MAX_PATTERN = 64,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // letter[4:0], zero fill
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // window_match[0], match_count[24:1], zero fill
  output logic        out_tlast   // done_res
);

  localparam int DIST_BITS = $clog2(MAX_PATTERN + 1);
  localparam logic [DIST_BITS-1:0] NONE = DIST_BITS'(MAX_PATTERN);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [psmc_pkg::POS_BITS-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic accept;
  psmc_pkg::cmd_t cmd;
  logic [psmc_pkg::LETTER_BITS-1:0] letter_raw, letter;
  logic last_r;

  logic [DIST_BITS-1:0] plen_r;
  logic [DIST_BITS-1:0] pseen_r [psmc_pkg::NUM_LETTERS];
  logic [DIST_BITS-1:0] tseen_r [psmc_pkg::NUM_LETTERS];
  logic [psmc_pkg::POS_BITS-1:0] pos_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [DIST_BITS-1:0] new_dist;
  logic [DIST_BITS-1:0] pat_dist;
  logic pat_app;
  psmc_pkg::cell_ctl_t ctl;

  logic [DIST_BITS-1:0] chain [MAX_PATTERN+1];
  logic [DIST_BITS-1:0] pchain [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] cell_ok;
  logic hit;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [psmc_pkg::OUT_COUNT_BITS-1:0] out_count;

  assign cmd = psmc_pkg::cmd_t'(in_tuser);
  assign letter_raw = in_tdata[4:0];
  assign letter = (letter_raw > psmc_pkg::LETTER_MAX) ? psmc_pkg::LETTER_MAX : letter_raw;
  assign in_tready = (state_r == ST_IDLE) && (!out_tvalid || out_tready);
  assign accept = in_tvalid && in_tready;
  assign pat_app = accept && (cmd == psmc_pkg::CMD_PATTERN) && (plen_r < NONE);
  assign pat_dist = (pseen_r[letter] < NONE) ? (plen_r - pseen_r[letter]) : '0;
  assign new_dist = (tseen_r[letter] < NONE) ? tseen_r[letter] : '0;

  assign ctl.text_en = accept && (cmd == psmc_pkg::CMD_TEXT);
  assign ctl.clear = (accept && (cmd == psmc_pkg::CMD_RESTART)) ||
                     (state_r == ST_EVAL && last_r);

  // State sequencing.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (ctl.text_en) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pattern bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && cmd == psmc_pkg::CMD_RESTART)) begin
      plen_r <= '0;
      for (int i = 0; i < psmc_pkg::NUM_LETTERS; i++) pseen_r[i] <= NONE;
    end else if (pat_app) begin
      plen_r <= plen_r + 1'b1;
      pseen_r[letter] <= plen_r;
    end
  end

  // Text letter distances and position.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < psmc_pkg::NUM_LETTERS; i++) tseen_r[i] <= NONE;
      pos_r <= '0;
    end else if (ctl.text_en) begin
      for (int i = 0; i < psmc_pkg::NUM_LETTERS; i++) begin
        if (i == int'(letter)) tseen_r[i] <= DIST_BITS'(1);
        else if (tseen_r[i] < NONE) tseen_r[i] <= tseen_r[i] + 1'b1;
      end
      if (pos_r < POS_MAX) pos_r <= pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.text_en) last_r <= in_tlast;
  end

  // Row of cells: the newest text and pattern distances enter at the top end.
  assign chain[MAX_PATTERN] = new_dist;
  assign pchain[MAX_PATTERN] = pat_dist;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    logic [DIST_BITS-1:0] off_k;
    logic active;
    // Cell g is window slot g; for length m it is offset k = g - (MAX - m).
    assign active = plen_r >= DIST_BITS'(MAX_PATTERN - g);
    assign off_k = plen_r - DIST_BITS'(MAX_PATTERN - g);
    psmc_cell #(.DIST_BITS(DIST_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .dist_in(chain[g+1]), .dist_out(chain[g]),
      .pat_we(pat_app), .pat_in(pchain[g+1]), .pat_out(pchain[g]),
      .off_k(off_k), .active(active), .ok(cell_ok[g])
    );
  end

  assign hit = (pos_r >= psmc_pkg::POS_BITS'(plen_r)) && (&cell_ok);
  assign cnt_next = (hit && cnt_r < CNT_MAX) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && cmd == psmc_pkg::CMD_RESTART) ||
        (state_r == ST_EVAL && last_r)) begin
      cnt_r <= '0;
    end else if (state_r == ST_EVAL) begin
      cnt_r <= cnt_next;
    end
  end

  // The reported count is clamped to the width of its field.
  always_comb begin
    if (COUNT_BITS > psmc_pkg::OUT_COUNT_BITS &&
        (cnt_next >> psmc_pkg::OUT_COUNT_BITS) != '0) begin
      out_count = '1;
    end else begin
      out_count = psmc_pkg::OUT_COUNT_BITS'(cnt_next);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (state_r == ST_EVAL) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EVAL) begin
      out_tdata <= {7'd0, out_count, hit};
      out_tlast <= last_r;
    end
  end

  `include "parameterized_substring_match_count_unit_macros.svh"

  `PSMC_ASSERT_NEXT(a_eval_one, state_r == ST_EVAL, state_r == ST_IDLE, "eval longer than one cycle")
  `PSMC_ASSERT_NEXT(a_eval_out, state_r == ST_EVAL, out_tvalid, "eval gave no result")
  `PSMC_ASSERT_IMPL(a_plen, 1'b1, plen_r <= NONE, "pattern length overflow")

endmodule
